// ===== rtl/tms_pkg.sv =====
// shared types, codes and constants for the timed measurement sequencer
// no dependencies; imported by every module of the block
package tms_pkg;

	localparam int unsigned CFG_W     = 24;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned Q_W       = 16;
	localparam int unsigned RAMP_W    = Q_W + 1;
	localparam int unsigned DIV_STEPS = Q_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_STEPS - 1);
	localparam logic [CFG_W-1:0] ELAPSED_MAX = '1;

	localparam logic [CFG_W-1:0] HOMING_RESET = CFG_W'(5000);
	localparam logic [CFG_W-1:0] DESCEND_RESET = CFG_W'(5000);
	localparam logic [CFG_W-1:0] SETTLE_RESET = CFG_W'(10000);
	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(10000);
	localparam logic [CFG_W-1:0] ASCEND_RESET = CFG_W'(5000);
	localparam logic [CFG_W-1:0] DWELL_RESET  = CFG_W'(1000);

	typedef enum logic [1:0] {
		MODE_DOCKED,
		MODE_MEASURING,
		MODE_FAULT
	} mode_t;

	typedef enum logic [2:0] {
		PH_NONE,
		PH_HOMING,
		PH_DESCENDING,
		PH_IN_WATER,
		PH_ASCENDING,
		PH_HOME
	} phase_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_START,
		OP_ABORT,
		OP_FAULT_RESET
	} op_t;

	typedef enum logic [2:0] {
		REG_HOMING,
		REG_DESCEND,
		REG_SETTLE,
		REG_WINDOW,
		REG_ASCEND,
		REG_DWELL
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CFG_W-1:0] homing;
		logic [CFG_W-1:0] descend;
		logic [CFG_W-1:0] settle;
		logic [CFG_W-1:0] window;
		logic [CFG_W-1:0] ascend;
		logic [CFG_W-1:0] dwell;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic need_div;
	} sts_t;

endpackage

// ===== rtl/tms_regs.sv =====
// apb configuration registers holding the six phase durations
// depends on tms_pkg
module tms_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tms_pkg::ADDR_W-1:0] paddr,
	input  logic [tms_pkg::DATA_W-1:0] pwdata,
	output logic [tms_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output tms_pkg::cfg_t              cfg
);
	import tms_pkg::*;

	cfg_t             cfg_q;
	reg_idx_t         idx;
	logic             wr_en;
	logic [CFG_W-1:0] wval;
	logic [CFG_W-1:0] rval;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign wval   = pwdata[CFG_W-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.homing  <= HOMING_RESET;
			cfg_q.descend <= DESCEND_RESET;
			cfg_q.settle  <= SETTLE_RESET;
			cfg_q.window  <= WINDOW_RESET;
			cfg_q.ascend  <= ASCEND_RESET;
			cfg_q.dwell   <= DWELL_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_HOMING:  cfg_q.homing  <= wval;
				REG_DESCEND: cfg_q.descend <= wval;
				REG_SETTLE:  cfg_q.settle  <= wval;
				REG_WINDOW:  cfg_q.window  <= wval;
				REG_ASCEND:  cfg_q.ascend  <= wval;
				REG_DWELL:   cfg_q.dwell   <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HOMING:  rval = cfg_q.homing;
			REG_DESCEND: rval = cfg_q.descend;
			REG_SETTLE:  rval = cfg_q.settle;
			REG_WINDOW:  rval = cfg_q.window;
			REG_ASCEND:  rval = cfg_q.ascend;
			REG_DWELL:   rval = cfg_q.dwell;
			default:     rval = '0;
		endcase
		prdata = psel ? DATA_W'(rval) : '0;
	end

endmodule

// ===== rtl/tms_datapath.sv =====
// sequencer state, command decode, ramp divider and result registers
// depends on tms_pkg; driven by tms_ctrl commands
module tms_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tms_pkg::cfg_t              cfg,
	input  tms_pkg::cmd_t              cmd,
	output tms_pkg::sts_t              sts,
	input  logic [1:0]                 opcode,
	input  logic                       take_mode_change,
	input  logic                       take_phase_change,
	output logic                       accepted,
	output logic [1:0]                 mode,
	output logic [2:0]                 phase,
	output logic                       mode_change_seen,
	output logic                       phase_change_seen,
	output logic [tms_pkg::RAMP_W-1:0] ramp_fraction,
	output logic                       reading_valid
);
	import tms_pkg::*;

	mode_t            mode_q, nm;
	phase_t           phase_q, np;
	logic [CFG_W-1:0] elapsed_q, ne;
	logic             mflag_q, pflag_q, nmf, npf;
	logic             acc, mseen, pseen, submerged, need_div;
	logic [CFG_W:0]   lim_sum;
	logic [CFG_W-1:0] water_lim;

	logic             acc_w_q, mseen_w_q, pseen_w_q, full_w_q;
	mode_t            mode_w_q;
	phase_t           phase_w_q;
	logic [CFG_W-1:0] rem_q;
	logic [Q_W-1:0]   quo_q;
	logic [CFG_W:0]   rem2, rem_sub;
	logic             ge;

	logic             acc_o_q, mseen_o_q, pseen_o_q, valid_o_q;
	logic [1:0]       mode_o_q;
	logic [2:0]       phase_o_q;
	logic [RAMP_W-1:0] ramp_o_q;

	assign lim_sum   = {1'b0, cfg.settle} + {1'b0, cfg.window};
	assign water_lim = lim_sum[CFG_W] ? ELAPSED_MAX : lim_sum[CFG_W-1:0];

	always_comb begin
		nm  = mode_q;
		np  = phase_q;
		ne  = elapsed_q;
		nmf = mflag_q;
		npf = pflag_q;
		acc = 1'b0;
		case (op_t'(opcode))
			OP_TICK: begin
				if (ne != ELAPSED_MAX) ne = ne + 1'b1;
				if (nm == MODE_MEASURING) begin
					case (np)
						PH_HOMING: begin
							if (ne >= cfg.homing) begin
								np = PH_DESCENDING; ne = '0; npf = 1'b1;
							end
						end
						PH_DESCENDING: begin
							if (ne >= cfg.descend) begin
								np = PH_IN_WATER; ne = '0; npf = 1'b1;
							end
						end
						PH_IN_WATER: begin
							if (ne >= water_lim) begin
								np = PH_ASCENDING; ne = '0; npf = 1'b1;
							end
						end
						PH_ASCENDING: begin
							if (ne >= cfg.ascend) begin
								np = PH_HOME; ne = '0; npf = 1'b1;
							end
						end
						PH_HOME: begin
							if (ne >= cfg.dwell) begin
								nm = MODE_DOCKED; nmf = 1'b1;
								np = PH_NONE; ne = '0; npf = 1'b1;
							end
						end
						default: begin
							nm = MODE_FAULT; nmf = 1'b1;
						end
					endcase
				end
			end
			OP_START: begin
				if (nm == MODE_DOCKED) begin
					nm = MODE_MEASURING; nmf = 1'b1;
					if (np != PH_HOMING) begin
						np = PH_HOMING; ne = '0; npf = 1'b1;
					end
					acc = 1'b1;
				end
			end
			OP_ABORT: begin
				if (nm != MODE_FAULT) begin
					nm = MODE_FAULT; nmf = 1'b1;
					if (np != PH_NONE) begin
						np = PH_NONE; ne = '0; npf = 1'b1;
					end
				end
			end
			default: begin
				if (nm == MODE_FAULT) begin
					nm = MODE_DOCKED; nmf = 1'b1;
					if (np != PH_NONE) begin
						np = PH_NONE; ne = '0; npf = 1'b1;
					end
					acc = 1'b1;
				end
			end
		endcase
		mseen = take_mode_change && nmf;
		pseen = take_phase_change && npf;
		if (take_mode_change) nmf = 1'b0;
		if (take_phase_change) npf = 1'b0;
		submerged = (nm == MODE_MEASURING) && (np == PH_IN_WATER);
		need_div  = submerged && (ne < cfg.settle);
	end

	assign sts.need_div = need_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_DOCKED;
			phase_q   <= PH_NONE;
			elapsed_q <= '0;
			mflag_q   <= 1'b0;
			pflag_q   <= 1'b0;
		end else if (cmd.load) begin
			mode_q    <= nm;
			phase_q   <= np;
			elapsed_q <= ne;
			mflag_q   <= nmf;
			pflag_q   <= npf;
		end
	end

	// restoring division, remainder stays below the divisor
	assign rem2    = {rem_q, 1'b0};
	assign ge      = rem2 >= {1'b0, cfg.settle};
	assign rem_sub = rem2 - {1'b0, cfg.settle};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_w_q   <= acc;
			mseen_w_q <= mseen;
			pseen_w_q <= pseen;
			mode_w_q  <= nm;
			phase_w_q <= np;
			full_w_q  <= submerged && !need_div;
			rem_q     <= ne;
			quo_q     <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[CFG_W-1:0] : rem2[CFG_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
		if (cmd.out_load) begin
			acc_o_q   <= acc_w_q;
			mode_o_q  <= mode_w_q;
			phase_o_q <= phase_w_q;
			mseen_o_q <= mseen_w_q;
			pseen_o_q <= pseen_w_q;
			ramp_o_q  <= {full_w_q, quo_q};
			valid_o_q <= full_w_q;
		end
	end

	assign accepted          = acc_o_q;
	assign mode              = mode_o_q;
	assign phase             = phase_o_q;
	assign mode_change_seen  = mseen_o_q;
	assign phase_change_seen = pseen_o_q;
	assign ramp_fraction     = ramp_o_q;
	assign reading_valid     = valid_o_q;

endmodule

// ===== rtl/tms_ctrl.sv =====
// controller: input beat acceptance, divider sequencing, output register handshake
// depends on tms_pkg; commands tms_datapath
module tms_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  tms_pkg::sts_t sts,
	output tms_pkg::cmd_t cmd
);
	import tms_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) cnt_q <= '0;
			else if (cmd.div_step) cnt_q <= cnt_q + 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.out_load = 1'b0;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.need_div ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && sts.need_div |=> state_q == ST_DIV && cnt_q == '0)
		else $error("divider not started after accepted beat");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && cnt_q == DIV_LAST |=> state_q == ST_DONE)
		else $error("divider ran past its last step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q && state_q == ST_IDLE)
		else $error("result load did not raise out_valid");

endmodule

// ===== rtl/timed_measurement_sequencer.sv =====
// top level of the timed measurement sequencer: apb registers, controller, datapath
// depends on tms_pkg, tms_regs, tms_ctrl, tms_datapath
// an accepted beat goes from ST_IDLE to ST_DONE, by way of ST_DIV when in water and settling,
// where the 16-step restoring divider computes the ramp fraction one quotient bit per cycle;
// in ST_DONE the result loads once the output is not stalled, then ST_IDLE takes the next beat
// reset: arst_n asynchronous active low; docked, phase none, flags and elapsed cleared
module timed_measurement_sequencer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tms_pkg::ADDR_W-1:0] paddr,
	input  logic [tms_pkg::DATA_W-1:0] pwdata,
	output logic [tms_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 opcode,
	input  logic                       take_mode_change,
	input  logic                       take_phase_change,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       accepted,
	output logic [1:0]                 mode,
	output logic [2:0]                 phase,
	output logic                       mode_change_seen,
	output logic                       phase_change_seen,
	output logic [tms_pkg::RAMP_W-1:0] ramp_fraction,
	output logic                       reading_valid
);
	import tms_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	tms_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tms_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.sts               (sts),
		.opcode            (opcode),
		.take_mode_change  (take_mode_change),
		.take_phase_change (take_phase_change),
		.accepted          (accepted),
		.mode              (mode),
		.phase             (phase),
		.mode_change_seen  (mode_change_seen),
		.phase_change_seen (phase_change_seen),
		.ramp_fraction     (ramp_fraction),
		.reading_valid     (reading_valid)
	);

endmodule

// ===== verif/tb_timed_measurement_sequencer.sv =====
`timescale 1ns / 1ps
// self-checking testbench for timed_measurement_sequencer: directed command and phase tests,
// then random command streams under varied handshake idling; depends on tms_pkg and the rtl
module tb_timed_measurement_sequencer;
	import tms_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned SEGMENT_ITEMS = 128;
	localparam int unsigned SETTLE_CYCLES = 24;

	typedef struct packed {
		logic               accepted;
		mode_t              mode;
		phase_t             phase;
		logic               mode_seen;
		logic               phase_seen;
		logic [RAMP_W-1:0]  ramp;
		logic               valid;
	} report_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        opcode = OP_TICK;
	logic              take_mode_change = 1'b0;
	logic              take_phase_change = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              accepted;
	logic [1:0]        mode;
	logic [2:0]        phase;
	logic              mode_change_seen;
	logic              phase_change_seen;
	logic [RAMP_W-1:0] ramp_fraction;
	logic              reading_valid;

	// sequencer state as predicted
	mode_t            probe_mode;
	phase_t           probe_phase;
	logic [CFG_W-1:0] phase_ticks;
	logic             mode_flag;
	logic             phase_flag;
	logic [CFG_W-1:0] durations [6];

	report_t pending_reports [$];
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned err_count = 0;
	int unsigned items_sent = 0;
	int unsigned results_checked = 0;
	int unsigned settling_results = 0;
	int unsigned config_count = 0;
	int unsigned cycle_count = 0;

	timed_measurement_sequencer uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.take_mode_change(take_mode_change), .take_phase_change(take_phase_change),
		.out_valid(out_valid), .out_stall(out_stall), .accepted(accepted), .mode(mode),
		.phase(phase), .mode_change_seen(mode_change_seen),
		.phase_change_seen(phase_change_seen), .ramp_fraction(ramp_fraction),
		.reading_valid(reading_valid)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_reports.size());
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic void enter_mode(input mode_t m);
		if (probe_mode != m) begin
			probe_mode = m;
			mode_flag = 1'b1;
		end
	endfunction

	function automatic void enter_phase(input phase_t p);
		if (probe_phase != p) begin
			probe_phase = p;
			phase_ticks = '0;
			phase_flag = 1'b1;
		end
	endfunction

	function automatic report_t advance_sequencer(input op_t cmd, input logic tm, input logic tp);
		report_t r;
		logic [CFG_W:0] window_end;
		logic [CFG_W+Q_W-1:0] scaled;
		r = '0;
		case (cmd)
			OP_TICK: begin
				if (phase_ticks != ELAPSED_MAX) phase_ticks++;
				if (probe_mode == MODE_MEASURING) begin
					case (probe_phase)
						PH_HOMING: begin
							if (phase_ticks >= durations[REG_HOMING]) enter_phase(PH_DESCENDING);
						end
						PH_DESCENDING: begin
							if (phase_ticks >= durations[REG_DESCEND]) enter_phase(PH_IN_WATER);
						end
						PH_IN_WATER: begin
							window_end = {1'b0, durations[REG_SETTLE]} +
								{1'b0, durations[REG_WINDOW]};
							if (window_end > {1'b0, ELAPSED_MAX}) window_end = {1'b0, ELAPSED_MAX};
							if ({1'b0, phase_ticks} >= window_end) enter_phase(PH_ASCENDING);
						end
						PH_ASCENDING: begin
							if (phase_ticks >= durations[REG_ASCEND]) enter_phase(PH_HOME);
						end
						PH_HOME: begin
							if (phase_ticks >= durations[REG_DWELL]) begin
								enter_mode(MODE_DOCKED);
								enter_phase(PH_NONE);
							end
						end
						default: begin
							enter_mode(MODE_FAULT);
						end
					endcase
				end
			end
			OP_START: begin
				if (probe_mode == MODE_DOCKED) begin
					enter_mode(MODE_MEASURING);
					enter_phase(PH_HOMING);
					r.accepted = 1'b1;
				end
			end
			OP_ABORT: begin
				if (probe_mode != MODE_FAULT) begin
					enter_mode(MODE_FAULT);
					enter_phase(PH_NONE);
				end
			end
			default: begin
				if (probe_mode == MODE_FAULT) begin
					enter_mode(MODE_DOCKED);
					enter_phase(PH_NONE);
					r.accepted = 1'b1;
				end
			end
		endcase
		if (tm) begin
			r.mode_seen = mode_flag;
			mode_flag = 1'b0;
		end
		if (tp) begin
			r.phase_seen = phase_flag;
			phase_flag = 1'b0;
		end
		if (probe_mode == MODE_MEASURING && probe_phase == PH_IN_WATER) begin
			if (phase_ticks < durations[REG_SETTLE]) begin
				scaled = {phase_ticks, {Q_W{1'b0}}};
				r.ramp = RAMP_W'(scaled / {{Q_W{1'b0}}, durations[REG_SETTLE]});
			end else begin
				r.ramp = RAMP_W'(1) << Q_W;
				r.valid = 1'b1;
			end
		end
		r.mode = probe_mode;
		r.phase = probe_phase;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [RAMP_W-1:0] want,
			input logic [RAMP_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual mode %0d phase %0d",
					$time, mode, phase);
				err_count++;
			end else begin
				want = pending_reports.pop_front();
				results_checked++;
				if (want.phase == PH_IN_WATER && !want.valid) settling_results++;
				check_field("accepted", want.accepted, accepted);
				check_field("mode", want.mode, mode);
				check_field("phase", want.phase, phase);
				check_field("mode_change_seen", want.mode_seen, mode_change_seen);
				check_field("phase_change_seen", want.phase_seen, phase_change_seen);
				check_field("ramp_fraction", want.ramp, ramp_fraction);
				check_field("reading_valid", want.valid, reading_valid);
			end
		end
	end

	task automatic send_cmd(input op_t cmd, input logic tm, input logic tp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= cmd;
		take_mode_change <= tm;
		take_phase_change <= tp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_reports.push_back(advance_sequencer(cmd, tm, tp));
		items_sent++;
	endtask

	// lets every outstanding beat come back, then waits out the divider
	task automatic drain_sequencer();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_duration(input reg_idx_t idx, input logic [CFG_W-1:0] ticks);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * idx);
		// upper bits are outside the register and must be dropped
		pwdata <= {8'($urandom_range(255)), ticks};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		durations[idx] = ticks;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== DATA_W'(ticks)) begin
			$display("%0t: register %0d readback expected %0d actual %0d",
				$time, idx, ticks, prdata);
			err_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_durations(input logic [CFG_W-1:0] homing, descend, settle, window,
			ascend, dwell);
		write_duration(REG_HOMING, homing);
		write_duration(REG_DESCEND, descend);
		write_duration(REG_SETTLE, settle);
		write_duration(REG_WINDOW, window);
		write_duration(REG_ASCEND, ascend);
		write_duration(REG_DWELL, dwell);
		config_count++;
	endtask

	function automatic logic [CFG_W-1:0] pick_ticks();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15) return '0;
		if (r < 80) return CFG_W'($urandom_range(1, 8));
		if (r < 94) return CFG_W'($urandom_range(9, 40));
		if (r < 97) return ELAPSED_MAX;
		return CFG_W'($urandom());
	endfunction

	// acceptance and rejection of commands across docked, measuring and fault modes, flag taking
	task automatic test_command_rules();
		send_cmd(OP_TICK, 1'b1, 1'b1);
		send_cmd(OP_START, 1'b0, 1'b0);
		send_cmd(OP_START, 1'b1, 1'b1);
		send_cmd(OP_ABORT, 1'b0, 1'b1);
		send_cmd(OP_ABORT, 1'b1, 1'b0);
		send_cmd(OP_START, 1'b0, 1'b0);
		send_cmd(OP_TICK, 1'b1, 1'b1);
		send_cmd(OP_FAULT_RESET, 1'b1, 1'b1);
		send_cmd(OP_FAULT_RESET, 1'b0, 1'b0);
		send_cmd(OP_ABORT, 1'b1, 1'b1);
		send_cmd(OP_FAULT_RESET, 1'b1, 1'b1);
	endtask

	// every phase ends on its first tick, in water is settled at once
	task automatic test_zero_durations();
		drain_sequencer();
		set_durations('0, '0, '0, '0, '0, '0);
		send_cmd(OP_START, 1'b1, 1'b1);
		repeat (5) send_cmd(OP_TICK, 1'b1, 1'b1);
	endtask

	// short settle ramp with a window so long that the in-water limit saturates
	task automatic test_saturated_window();
		drain_sequencer();
		set_durations('0, '0, CFG_W'(3), ELAPSED_MAX, CFG_W'(1), ELAPSED_MAX);
		send_cmd(OP_START, 1'b0, 1'b0);
		repeat (6) send_cmd(OP_TICK, 1'b0, 1'b1);
		send_cmd(OP_ABORT, 1'b1, 1'b1);
		send_cmd(OP_FAULT_RESET, 1'b1, 1'b1);
	endtask

	// mostly full measurement cycles, with aborts and random noise commands
	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_p);
		op_t cmd;
		drain_sequencer();
		send_idle_pct = idle_pct;
		stall_pct = stall_p;
		repeat (2) begin
			drain_sequencer();
			set_durations(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks(),
				pick_ticks(), pick_ticks());
			repeat (SEGMENT_ITEMS) begin
				if ($urandom_range(99) < 8) begin
					cmd = op_t'($urandom_range(3));
				end else begin
					case (probe_mode)
						MODE_DOCKED: cmd = ($urandom_range(99) < 35) ? OP_START : OP_TICK;
						MODE_FAULT: cmd = ($urandom_range(99) < 40) ? OP_FAULT_RESET : OP_TICK;
						default: cmd = ($urandom_range(99) < 2) ? OP_ABORT : OP_TICK;
					endcase
				end
				send_cmd(cmd, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		probe_mode = MODE_DOCKED;
		probe_phase = PH_NONE;
		phase_ticks = '0;
		mode_flag = 1'b0;
		phase_flag = 1'b0;
		durations[REG_HOMING] = HOMING_RESET;
		durations[REG_DESCEND] = DESCEND_RESET;
		durations[REG_SETTLE] = SETTLE_RESET;
		durations[REG_WINDOW] = WINDOW_RESET;
		durations[REG_ASCEND] = ASCEND_RESET;
		durations[REG_DWELL] = DWELL_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_command_rules();
		test_zero_durations();
		test_saturated_window();
		test_random_traffic(0, 0);
		test_random_traffic(79, 0);
		test_random_traffic(0, 79);
		test_random_traffic(6, 6);
		drain_sequencer();
		$display("ran %0d commands across %0d duration settings and four handshake mixes",
			items_sent, config_count);
		$display("checked %0d results, %0d of them on the settle ramp",
			results_checked, settling_results);
		if (err_count == 0 && pending_reports.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
